/* src/pwcf_pkg.sv */
// ----------------------------------------------------------------------------
// pwcf_pkg - shared types and codes for the pulse width capture queue
// Function codes, the queue entry layout and the queue control structs.
// ----------------------------------------------------------------------------
package pwcf_pkg;

    localparam int QueueDepthDefault = 32;

    // item function codes
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [1:0] FUNC_EDGE   = 2'd2;
    localparam logic [1:0] FUNC_POP    = 2'd3;

    localparam logic [15:0] DURATION_SATURATED = 16'hFFFF;

    typedef struct packed {
        logic [15:0] duration;
        logic        level_before;
        logic [7:0]  rssi_peak;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_req_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic single;   // exactly one entry held
    } queue_status_t;

endpackage

/* src/pwcf_queue.sv */
// ----------------------------------------------------------------------------
// pwcf_queue - ring queue of capture entries
// Single-port entry memory with registered read data, ring pointers and
// an occupancy count. Caller gates push on full and pop on empty.
// ----------------------------------------------------------------------------
module pwcf_queue #(
    parameter int QUEUE_DEPTH = pwcf_pkg::QueueDepthDefault
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pwcf_pkg::queue_req_t    req,
    input  pwcf_pkg::entry_t        wr_entry,
    output pwcf_pkg::entry_t        rd_entry,
    output pwcf_pkg::queue_status_t status
);
    import pwcf_pkg::*;

    localparam int PtrW   = $clog2(QUEUE_DEPTH);
    localparam int CountW = $clog2(QUEUE_DEPTH + 1);

    entry_t entry_mem [QUEUE_DEPTH];
    entry_t rd_entry_reg;

    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CountW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (req.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        else if (req.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // one access per cycle: push and pop never come together
    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            entry_mem[wr_ptr_reg] <= wr_entry;
        end
        if (req.pop)
        begin
            rd_entry_reg <= entry_mem[rd_ptr_reg];
        end
    end

    assign rd_entry      = rd_entry_reg;
    assign status.empty  = (count_reg == '0);
    assign status.full   = (count_reg == CountW'(QUEUE_DEPTH));
    assign status.single = (count_reg == CountW'(1));

endmodule

/* src/pulse_width_capture_fifo_core.sv */
// ----------------------------------------------------------------------------
// pulse_width_capture_fifo_core - edge interval capture with entry queue
// Times the gaps between signal edges, holds the peak strength per gap and
// queues one entry per edge for later read-out.
// ----------------------------------------------------------------------------
// The block takes one beat per cycle while in_ready is high and returns one
// result beat for every input beat, through stage 1 and the output stage.
// A tick beat advances the 16-bit interval counter (saturating the captured
// duration at 0xFFFF after a wrap), a sample beat updates the peak hold with
// adc_value[9:2], an edge beat pushes {duration, level before edge, peak}
// and clears the interval state, and a pop beat reads the oldest entry. The
// queue holds QUEUE_DEPTH entries in one single-port memory; each beat makes
// at most one access to it, and popped data passes from the registered read
// to a result stage, so no forwarding is needed. An edge that finds the queue
// full is dropped and flagged with overrun; a pop on an empty queue returns
// entry_valid low with zero fields. pending tells whether entries remain
// after the beat. The memory is not cleared at reset: entries are only read
// after being written, so the block is ready right after reset.
// ----------------------------------------------------------------------------
module pulse_width_capture_fifo_core #(
    parameter int QUEUE_DEPTH = pwcf_pkg::QueueDepthDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic        pin_level,
    input  logic [9:0]  adc_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        pending,
    output logic        entry_valid,
    output logic [15:0] duration,
    output logic        level_before,
    output logic [7:0]  rssi_peak,
    output logic        overrun
);
    import pwcf_pkg::*;

    // interval state
    logic [15:0] tick_reg, tick_next;
    logic        ovf_reg, ovf_next;
    logic [7:0]  peak_reg, peak_next;

    // stage 1: beat decoded, queue read in flight
    logic s1_valid_reg, s1_valid_next;
    logic s1_pending_reg;
    logic s1_pop_reg;
    logic s1_ovr_reg;

    // output stage
    logic        out_valid_reg, out_valid_next;
    logic        pending_reg;
    logic        entry_valid_reg;
    logic [15:0] duration_reg;
    logic        level_before_reg;
    logic [7:0]  rssi_peak_reg;
    logic        overrun_reg;

    logic          in_acc;
    logic          is_edge;
    logic          is_pop;
    logic          out_load;
    logic          s1_move;
    logic          pending_new;
    logic [7:0]    sample;
    queue_req_t    q_req;
    queue_status_t q_status;
    entry_t        q_wr_entry;
    entry_t        q_rd_entry;

    assign out_load = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_move  = out_load;
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_acc   = in_valid && in_ready;
    assign is_edge  = (func == FUNC_EDGE);
    assign is_pop   = (func == FUNC_POP);
    assign sample   = adc_value[9:2];

    assign q_req.push = in_acc && is_edge && !q_status.full;
    assign q_req.pop  = in_acc && is_pop && !q_status.empty;

    assign q_wr_entry.duration     = ovf_reg ? DURATION_SATURATED : tick_reg;
    assign q_wr_entry.level_before = ~pin_level;
    assign q_wr_entry.rssi_peak    = peak_reg;

    // occupancy after this beat
    always_comb
    begin
        if (q_req.push)
        begin
            pending_new = 1'b1;
        end
        else if (q_req.pop)
        begin
            pending_new = !q_status.single;
        end
        else
        begin
            pending_new = !q_status.empty;
        end
    end

    always_comb
    begin
        tick_next = tick_reg;
        ovf_next  = ovf_reg;
        peak_next = peak_reg;
        if (in_acc)
        begin
            case (func)
                FUNC_TICK:
                begin
                    tick_next = tick_reg + 16'd1;   // wraps to zero at 0xFFFF
                    if (tick_reg == 16'hFFFF)
                    begin
                        ovf_next = 1'b1;
                    end
                end
                FUNC_SAMPLE:
                begin
                    if (sample > peak_reg)
                    begin
                        peak_next = sample;
                    end
                end
                FUNC_EDGE:
                begin
                    tick_next = '0;
                    ovf_next  = 1'b0;
                    peak_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            ovf_reg       <= 1'b0;
            peak_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tick_reg      <= tick_next;
            ovf_reg       <= ovf_next;
            peak_reg      <= peak_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_pending_reg <= pending_new;
            s1_pop_reg     <= q_req.pop;
            s1_ovr_reg     <= in_acc && is_edge && q_status.full;
        end
        if (out_load)
        begin
            pending_reg      <= s1_pending_reg;
            entry_valid_reg  <= s1_pop_reg;
            duration_reg     <= s1_pop_reg ? q_rd_entry.duration : 16'd0;
            level_before_reg <= s1_pop_reg ? q_rd_entry.level_before : 1'b0;
            rssi_peak_reg    <= s1_pop_reg ? q_rd_entry.rssi_peak : 8'd0;
            overrun_reg      <= s1_ovr_reg;
        end
    end

    pwcf_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (q_req),
        .wr_entry (q_wr_entry),
        .rd_entry (q_rd_entry),
        .status   (q_status)
    );

    assign out_valid    = out_valid_reg;
    assign pending      = pending_reg;
    assign entry_valid  = entry_valid_reg;
    assign duration     = duration_reg;
    assign level_before = level_before_reg;
    assign rssi_peak    = rssi_peak_reg;
    assign overrun      = overrun_reg;

    // a dropped edge means the queue was full, so entries remain
    a_overrun_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overrun) |-> (pending && !entry_valid))
        else $error("overrun reported with empty queue or with an entry");

    // pop on empty queue must not yield an entry
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && is_pop && q_status.empty) |=> !s1_pop_reg)
        else $error("entry returned from empty queue");

    // occupancy flags stay consistent
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.empty && q_status.full) && !(q_status.empty && q_status.single))
        else $error("queue status flags conflict");

    // a stalled stage 1 beat blocks intake
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("beat accepted into a stalled pipeline");

endmodule

/* sim/tb_pulse_width_capture_fifo_core.sv */
// ----------------------------------------------------------------------------
// tb_pulse_width_capture_fifo_core - self-checking bench for the capture queue
// Feeds tick, sample, edge and pop beats through the input handshake and
// checks each result beat against an in-bench copy of the capture state.
// Covers the empty pop, the full-queue overrun, long intervals, random idles
// on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_pulse_width_capture_fifo_core;

    import pwcf_pkg::*;

    localparam int QUEUE_DEPTH    = QueueDepthDefault;
    localparam int RANDOM_BEATS   = 1000;
    localparam int CALM_FIRST     = 300;    // no idling on either side in this
    localparam int CALM_LAST      = 700;    // range of beat counts
    localparam int STALL_AFTER    = 900;    // results seen before the long stall
    localparam int STALL_CYCLES   = 150;
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no beat on either side
    localparam int DRAIN_CYCLES   = 10;

    // one input beat as driven on the ports
    typedef struct packed {
        logic [1:0] func;
        logic       pin_level;
        logic [9:0] adc_value;
    } capture_event_t;

    // one result beat, field for field
    typedef struct packed {
        logic        pending;
        logic        entry_valid;
        logic [15:0] duration;
        logic        level_before;
        logic [7:0]  rssi_peak;
        logic        overrun;
    } capture_readout_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [1:0]  func         = FUNC_TICK;
    logic        pin_level    = 1'b0;
    logic [9:0]  adc_value    = '0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic        pending;
    logic        entry_valid;
    logic [15:0] duration;
    logic        level_before;
    logic [7:0]  rssi_peak;
    logic        overrun;

    capture_event_t   capture_events[$];      // beats still to be offered
    capture_readout_t predicted_readouts[$];  // results owed by the block
    capture_event_t   on_port;                // beat currently on the inputs

    // capture state as the block should hold it
    logic [15:0] tick_cnt;
    logic        tick_wrapped;
    logic [7:0]  peak_hold;
    entry_t      entry_mem[QUEUE_DEPTH];
    int          wr_ptr;
    int          rd_ptr;
    int          fill_level;

    int beats_sent;
    int results_seen;
    int mismatches;
    int stall_left;
    bit stall_done;
    int quiet_cycles;

    pulse_width_capture_fifo_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .pin_level    (pin_level),
        .adc_value    (adc_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pending      (pending),
        .entry_valid  (entry_valid),
        .duration     (duration),
        .level_before (level_before),
        .rssi_peak    (rssi_peak),
        .overrun      (overrun)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Capture state update for one accepted beat; queues the result it owes.
    // ------------------------------------------------------------------------
    task automatic apply_capture_event(input capture_event_t ev);
        capture_readout_t r;
        r = '0;
        case (ev.func)
            FUNC_TICK:
            begin
                // wrap sets the mark that saturates the next captured duration
                if (tick_cnt == 16'hFFFF)
                begin
                    tick_cnt     = '0;
                    tick_wrapped = 1'b1;
                end
                else
                begin
                    tick_cnt = tick_cnt + 16'd1;
                end
            end
            FUNC_SAMPLE:
            begin
                if (ev.adc_value[9:2] > peak_hold)
                    peak_hold = ev.adc_value[9:2];
            end
            FUNC_EDGE:
            begin
                if (fill_level == QUEUE_DEPTH)
                begin
                    r.overrun = 1'b1;     // entry lost, interval still closes
                end
                else
                begin
                    entry_mem[wr_ptr].duration     = tick_wrapped ? DURATION_SATURATED
                                                                  : tick_cnt;
                    entry_mem[wr_ptr].level_before = ~ev.pin_level;
                    entry_mem[wr_ptr].rssi_peak    = peak_hold;
                    wr_ptr     = (wr_ptr == QUEUE_DEPTH - 1) ? 0 : wr_ptr + 1;
                    fill_level = fill_level + 1;
                end
                tick_cnt     = '0;
                tick_wrapped = 1'b0;
                peak_hold    = '0;
            end
            FUNC_POP:
            begin
                // empty queue: refused, all entry fields stay zero
                if (fill_level != 0)
                begin
                    r.entry_valid  = 1'b1;
                    r.duration     = entry_mem[rd_ptr].duration;
                    r.level_before = entry_mem[rd_ptr].level_before;
                    r.rssi_peak    = entry_mem[rd_ptr].rssi_peak;
                    rd_ptr     = (rd_ptr == QUEUE_DEPTH - 1) ? 0 : rd_ptr + 1;
                    fill_level = fill_level - 1;
                end
            end
            default:
            begin
            end
        endcase
        r.pending = (fill_level != 0);
        predicted_readouts.push_back(r);
    endtask

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at result %0d, %s: got %0h, expected %0h",
                 results_seen, field, got, want);
        mismatches = mismatches + 1;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus builders. Random beats carry random don't-care fields.
    // ------------------------------------------------------------------------
    task automatic add_event(input logic [1:0] f, input logic pin, input logic [9:0] adc);
        capture_event_t ev;
        ev.func      = f;
        ev.pin_level = pin;
        ev.adc_value = adc;
        capture_events.push_back(ev);
    endtask

    function automatic logic [9:0] pick_adc();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 10'h3FF;
        else if (roll < 15)
            return 10'h000;
        return 10'($urandom_range(0, 1023));
    endfunction

    // ticks and samples in random order, closed by an edge
    task automatic add_interval(input int n_ticks, input int n_samples);
        while (n_ticks + n_samples > 0)
        begin
            if (n_samples == 0 || (n_ticks > 0 && $urandom_range(0, 1) == 0))
            begin
                add_event(FUNC_TICK, 1'($urandom), 10'($urandom));
                n_ticks = n_ticks - 1;
            end
            else
            begin
                add_event(FUNC_SAMPLE, 1'($urandom), pick_adc());
                n_samples = n_samples - 1;
            end
        end
        add_event(FUNC_EDGE, 1'($urandom), 10'($urandom));
    endtask

    task automatic add_pops(input int n);
        repeat (n)
            add_event(FUNC_POP, 1'($urandom), 10'($urandom));
    endtask

    task automatic add_ticks(input int n);
        repeat (n)
            add_event(FUNC_TICK, 1'($urandom), 10'($urandom));
    endtask

    task automatic build_stimulus();
        int roll;
        int target;

        // directed: empty pop, edge with nothing measured, peak hold extremes
        add_pops(1);
        add_event(FUNC_EDGE, 1'b1, 10'h000);
        add_event(FUNC_SAMPLE, 1'b0, 10'h3FF);
        add_event(FUNC_SAMPLE, 1'b1, 10'h003);      // shifts to zero
        add_event(FUNC_SAMPLE, 1'b0, 10'h004);
        add_ticks(3);
        add_event(FUNC_EDGE, 1'b0, 10'h3FF);
        add_event(FUNC_SAMPLE, 1'b1, 10'h2AA);
        add_event(FUNC_SAMPLE, 1'b0, 10'h155);      // smaller, peak keeps 0xAA
        add_event(FUNC_TICK, 1'b1, 10'h155);
        add_event(FUNC_EDGE, 1'b1, 10'h2AA);
        add_pops(4);                                // last one hits empty
        add_event(FUNC_SAMPLE, 1'b0, 10'h001);
        add_event(FUNC_EDGE, 1'b0, 10'h001);
        add_pops(1);

        // fill past the queue depth, then drain past empty
        repeat (QUEUE_DEPTH + 2)
            add_interval($urandom_range(0, 3), $urandom_range(0, 2));
        add_pops(QUEUE_DEPTH + 2);

        // random part: mostly closed intervals and pop runs
        target = capture_events.size() + RANDOM_BEATS;
        while (capture_events.size() < target)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
                add_interval(($urandom_range(0, 99) < 3) ? $urandom_range(100, 300)
                                                         : $urandom_range(0, 12),
                             $urandom_range(0, 3));
            else if (roll < 80)
                add_pops($urandom_range(1, 6));
            else if (roll < 86)
                repeat ($urandom_range(8, 36))
                    add_event(FUNC_EDGE, 1'($urandom), 10'($urandom));
            else if (roll < 92)
                add_pops($urandom_range(20, 40));
            else
                repeat ($urandom_range(1, 4))
                    add_event(2'($urandom), 1'($urandom), 10'($urandom));
        end

        // drain whatever the random part left, one pop past empty
        add_pops(QUEUE_DEPTH + 1);
    endtask

    // ------------------------------------------------------------------------
    // Input side: offer the next beat, or idle at random outside the calm
    // window. Payload holds while valid waits for ready.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_capture_event(on_port);
                beats_sent = beats_sent + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (capture_events.size() != 0 &&
                    ((beats_sent >= CALM_FIRST && beats_sent < CALM_LAST) ||
                     $urandom_range(0, 99) >= 11))
                begin
                    on_port = capture_events.pop_front();
                    in_valid  <= 1'b1;
                    func      <= on_port.func;
                    pin_level <= on_port.pin_level;
                    adc_value <= on_port.adc_value;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long output stall once, so the input side backs up and stalls too.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_left <= 0;
            stall_done <= 1'b0;
        end
        else if (!stall_done && results_seen >= STALL_AFTER)
        begin
            stall_left <= STALL_CYCLES;
            stall_done <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Output side: check each accepted result against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        capture_readout_t want;
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            results_seen <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_readouts.size() == 0)
                begin
                    report_mismatch("unexpected result beat", 1, 0);
                end
                else
                begin
                    want = predicted_readouts.pop_front();
                    if (pending !== want.pending)
                        report_mismatch("pending", pending, want.pending);
                    if (entry_valid !== want.entry_valid)
                        report_mismatch("entry_valid", entry_valid, want.entry_valid);
                    if (duration !== want.duration)
                        report_mismatch("duration", duration, want.duration);
                    if (level_before !== want.level_before)
                        report_mismatch("level_before", level_before, want.level_before);
                    if (rssi_peak !== want.rssi_peak)
                        report_mismatch("rssi_peak", rssi_peak, want.rssi_peak);
                    if (overrun !== want.overrun)
                        report_mismatch("overrun", overrun, want.overrun);
                end
                results_seen <= results_seen + 1;
            end
            out_ready <= (stall_left == 0) &&
                         ((results_seen >= CALM_FIRST && results_seen < CALM_LAST) ||
                          $urandom_range(0, 99) >= 11);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long with no beat on either side ends the run.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", quiet_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        tick_cnt     = '0;
        tick_wrapped = 1'b0;
        peak_hold    = '0;
        wr_ptr       = 0;
        rd_ptr       = 0;
        fill_level   = 0;
        beats_sent   = 0;
        mismatches   = 0;
        quiet_cycles = 0;
        build_stimulus();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // run until every beat is in and every result is out
        do
            @(negedge clk);
        while (capture_events.size() != 0 || in_valid || predicted_readouts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
